### rtl/sti_pkg.sv
// Shared constants for the segment/triangle crossing pipeline.
// No dependencies.
package sti_pkg;
	localparam int IN_W   = 48;
	localparam int OUT_W  = 16;
	localparam int T_FRAC = 16;
	localparam int S_DATA_W = 6 * IN_W;
	localparam int M_DATA_W = ((1 + 3 * OUT_W + 7) / 8) * 8;
endpackage

### rtl/segment_triangle_intersect.sv
// Segment/triangle crossing test, fully pipelined stream block.
// Depends on sti_pkg (field widths, crossing parameter fraction bits).
// Throughput one beat per cycle while the output is not stalled.
// The divider for t is 17 pipeline stages, one quotient bit per stage.
// Any output stall halts the whole pipeline; nothing is lost or repeated.
// Reset (arst_n low, asynchronous) clears all valid bits; data registers are not reset.
module segment_triangle_intersect #(
	parameter int COORD_BITS = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_axis_tvalid,
	output logic                          s_axis_tready,
	// vert_a, vert_b, vert_c, plane_normal, seg_start, seg_end (48 bits each)
	input  logic [sti_pkg::S_DATA_W-1:0]  s_axis_tdata,
	output logic                          m_axis_tvalid,
	input  logic                          m_axis_tready,
	// hit, hit_x, hit_y, hit_z, zero pad
	output logic [sti_pkg::M_DATA_W-1:0]  m_axis_tdata
);
	import sti_pkg::*;

	localparam int C   = COORD_BITS;
	localparam int DW  = C + 1;
	localparam int MW  = 2 * C + 1;
	localparam int RW  = 2 * C + 3;
	localparam int DNW = RW + 1;
	localparam int TW  = T_FRAC + 1;
	localparam int SCW = DW + TW + 1;
	localparam int XPW = 2 * DW;
	localparam int XW  = 2 * C + 3;
	localparam int LO  = (XW + 1) / 2;
	localparam int HI  = XW - LO;
	localparam int LPW = LO + 1 + C;
	localparam int HPW = HI + C;
	localparam int LSW = LPW + 2;
	localparam int HSW = HPW + 2;
	localparam int PW  = 3 * C + 5;
	localparam int OB  = (C < OUT_W) ? C : OUT_W;

	typedef logic signed [C-1:0]  crd_t;
	typedef logic signed [DW-1:0] dif_t;
	typedef struct packed { crd_t x; crd_t y; crd_t z; } vec_t;
	typedef struct packed { dif_t x; dif_t y; dif_t z; } dvec_t;
	typedef struct packed {
		vec_t  a;
		vec_t  b;
		vec_t  c;
		vec_t  n;
		vec_t  p1;
		dvec_t d;
		logic  miss;
	} carry_t;

	function automatic vec_t unpack(input logic [IN_W-1:0] f);
		logic [3*C-1:0] e;
		vec_t r;
		e = (3*C)'(f);
		r.x = e[C-1:0];
		r.y = e[2*C-1:C];
		r.z = e[3*C-1:2*C];
		return r;
	endfunction

	function automatic dvec_t vsub(input vec_t p, input vec_t q);
		dvec_t r;
		r.x = DW'(p.x) - DW'(q.x);
		r.y = DW'(p.y) - DW'(q.y);
		r.z = DW'(p.z) - DW'(q.z);
		return r;
	endfunction

	logic en;
	assign en = !m_axis_tvalid || m_axis_tready;
	assign s_axis_tready = en;

	// stage 1: unpack and differences
	logic  v_s1;
	vec_t  a_s1, b_s1, c_s1, n_s1, p1_s1;
	dvec_t q1_s1, q2_s1, d_s1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s1 <= 1'b0;
		else if (en) v_s1 <= s_axis_tvalid;
	end
	always_ff @(posedge clk) begin
		vec_t ua, ub, uc, un, u1, u2;
		ua = unpack(s_axis_tdata[IN_W-1:0]);
		ub = unpack(s_axis_tdata[2*IN_W-1:IN_W]);
		uc = unpack(s_axis_tdata[3*IN_W-1:2*IN_W]);
		un = unpack(s_axis_tdata[4*IN_W-1:3*IN_W]);
		u1 = unpack(s_axis_tdata[5*IN_W-1:4*IN_W]);
		u2 = unpack(s_axis_tdata[6*IN_W-1:5*IN_W]);
		if (en) begin
			a_s1  <= ua;
			b_s1  <= ub;
			c_s1  <= uc;
			n_s1  <= un;
			p1_s1 <= u1;
			q1_s1 <= vsub(u1, ua);
			q2_s1 <= vsub(u2, ua);
			d_s1  <= vsub(u2, u1);
		end
	end

	// stage 2: plane distance products
	logic v_s2;
	carry_t c_s2;
	logic signed [MW-1:0] m1_s2 [3];
	logic signed [MW-1:0] m2_s2 [3];
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s2 <= 1'b0;
		else if (en) v_s2 <= v_s1;
	end
	always_ff @(posedge clk) begin
		if (en) begin
			c_s2 <= '{a: a_s1, b: b_s1, c: c_s1, n: n_s1, p1: p1_s1, d: d_s1, miss: 1'b0};
			m1_s2[0] <= n_s1.x * q1_s1.x;
			m1_s2[1] <= n_s1.y * q1_s1.y;
			m1_s2[2] <= n_s1.z * q1_s1.z;
			m2_s2[0] <= n_s1.x * q2_s1.x;
			m2_s2[1] <= n_s1.y * q2_s1.y;
			m2_s2[2] <= n_s1.z * q2_s1.z;
		end
	end

	// stage 3: distances
	logic v_s3;
	carry_t c_s3;
	logic signed [RW-1:0] r1_s3, r2_s3;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s3 <= 1'b0;
		else if (en) v_s3 <= v_s2;
	end
	always_ff @(posedge clk) begin
		if (en) begin
			c_s3  <= c_s2;
			r1_s3 <= RW'(m1_s2[0]) + RW'(m1_s2[1]) + RW'(m1_s2[2]);
			r2_s3 <= RW'(m2_s2[0]) + RW'(m2_s2[1]) + RW'(m2_s2[2]);
		end
	end

	// stage 4: sign test and divider operands
	logic                 dv_v_s   [TW+1];
	carry_t               dv_c_s   [TW+1];
	logic [DNW:0]         dv_rem_s [TW+1];
	logic [DNW-1:0]       dv_den_s [TW+1];
	logic [TW-1:0]        dv_q_s   [TW+1];

	logic signed [DNW-1:0] num_w, den_w, num_n, den_n;
	logic miss_w;
	always_comb begin
		num_w = -DNW'(r1_s3);
		den_w = DNW'(r2_s3) - DNW'(r1_s3);
		if (den_w[DNW-1]) begin
			num_n = -num_w;
			den_n = -den_w;
		end else begin
			num_n = num_w;
			den_n = den_w;
		end
		miss_w = (r1_s3[RW-1] == r2_s3[RW-1]) && ((r1_s3 == '0) == (r2_s3 == '0));
	end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) dv_v_s[0] <= 1'b0;
		else if (en) dv_v_s[0] <= v_s3;
	end
	always_ff @(posedge clk) begin
		if (en) begin
			carry_t cw;
			cw = c_s3;
			cw.miss = miss_w;
			dv_c_s[0]   <= cw;
			dv_rem_s[0] <= (DNW+1)'(unsigned'(num_n));
			dv_den_s[0] <= unsigned'(den_n);
			dv_q_s[0]   <= '0;
		end
	end

	// stages 5..21: restoring divider, one quotient bit per stage
	for (genvar k = 0; k < TW; k++) begin : g_div
		logic [DNW:0] r_in, r_sub;
		logic         qb;
		if (k == 0) begin : g_first
			assign r_in = dv_rem_s[k];
		end else begin : g_next
			assign r_in = {dv_rem_s[k][DNW-1:0], 1'b0};
		end
		assign qb    = r_in >= {1'b0, dv_den_s[k]};
		assign r_sub = qb ? (r_in - {1'b0, dv_den_s[k]}) : r_in;
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) dv_v_s[k+1] <= 1'b0;
			else if (en) dv_v_s[k+1] <= dv_v_s[k];
		end
		always_ff @(posedge clk) begin
			if (en) begin
				dv_c_s[k+1]   <= dv_c_s[k];
				dv_rem_s[k+1] <= r_sub;
				dv_den_s[k+1] <= dv_den_s[k];
				dv_q_s[k+1]   <= {dv_q_s[k][TW-2:0], qb};
			end
		end
	end

	// stage 22: scale segment direction by t
	logic v_s22;
	carry_t c_s22;
	logic signed [SCW-1:0] sc_s22 [3];
	logic signed [TW:0] t_sg;
	assign t_sg = $signed({1'b0, dv_q_s[TW]});
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s22 <= 1'b0;
		else if (en) v_s22 <= dv_v_s[TW];
	end
	always_ff @(posedge clk) begin
		if (en) begin
			c_s22     <= dv_c_s[TW];
			sc_s22[0] <= dv_c_s[TW].d.x * t_sg;
			sc_s22[1] <= dv_c_s[TW].d.y * t_sg;
			sc_s22[2] <= dv_c_s[TW].d.z * t_sg;
		end
	end

	// stage 23: crossing point and edge vectors
	logic v_s23, miss_s23;
	vec_t ip_s23, n_s23;
	dvec_t eu_s23 [3];
	dvec_t ev_s23 [3];
	vec_t ip_w;
	always_comb begin
		logic signed [SCW-1:0] fx, fy, fz;
		fx = sc_s22[0] >>> T_FRAC;
		fy = sc_s22[1] >>> T_FRAC;
		fz = sc_s22[2] >>> T_FRAC;
		ip_w.x = C'(SCW'(c_s22.p1.x) + fx);
		ip_w.y = C'(SCW'(c_s22.p1.y) + fy);
		ip_w.z = C'(SCW'(c_s22.p1.z) + fz);
	end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s23 <= 1'b0;
		else if (en) v_s23 <= v_s22;
	end
	always_ff @(posedge clk) begin
		if (en) begin
			miss_s23  <= c_s22.miss;
			ip_s23    <= ip_w;
			n_s23     <= c_s22.n;
			eu_s23[0] <= vsub(c_s22.b, c_s22.a);
			eu_s23[1] <= vsub(c_s22.c, c_s22.b);
			eu_s23[2] <= vsub(c_s22.a, c_s22.c);
			ev_s23[0] <= vsub(ip_w, c_s22.a);
			ev_s23[1] <= vsub(ip_w, c_s22.b);
			ev_s23[2] <= vsub(ip_w, c_s22.c);
		end
	end

	// stage 24: cross product terms
	logic v_s24, miss_s24;
	vec_t ip_s24, n_s24;
	logic signed [XPW-1:0] xp_s24 [3][6];
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s24 <= 1'b0;
		else if (en) v_s24 <= v_s23;
	end
	always_ff @(posedge clk) begin
		if (en) begin
			miss_s24 <= miss_s23;
			ip_s24   <= ip_s23;
			n_s24    <= n_s23;
			for (int e = 0; e < 3; e++) begin
				xp_s24[e][0] <= eu_s23[e].y * ev_s23[e].z;
				xp_s24[e][1] <= eu_s23[e].z * ev_s23[e].y;
				xp_s24[e][2] <= eu_s23[e].z * ev_s23[e].x;
				xp_s24[e][3] <= eu_s23[e].x * ev_s23[e].z;
				xp_s24[e][4] <= eu_s23[e].x * ev_s23[e].y;
				xp_s24[e][5] <= eu_s23[e].y * ev_s23[e].x;
			end
		end
	end

	// stage 25: cross product components
	logic v_s25, miss_s25;
	vec_t ip_s25, n_s25;
	logic signed [XW-1:0] xc_s25 [3][3];
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s25 <= 1'b0;
		else if (en) v_s25 <= v_s24;
	end
	always_ff @(posedge clk) begin
		if (en) begin
			miss_s25 <= miss_s24;
			ip_s25   <= ip_s24;
			n_s25    <= n_s24;
			for (int e = 0; e < 3; e++) begin
				for (int j = 0; j < 3; j++) begin
					xc_s25[e][j] <= XW'(xp_s24[e][2*j]) - XW'(xp_s24[e][2*j+1]);
				end
			end
		end
	end

	// stage 26: split partial products against the normal
	logic v_s26, miss_s26;
	vec_t ip_s26;
	logic signed [LPW-1:0] lp_s26 [3][3];
	logic signed [HPW-1:0] hp_s26 [3][3];
	crd_t ncomp [3];
	assign ncomp[0] = n_s25.x;
	assign ncomp[1] = n_s25.y;
	assign ncomp[2] = n_s25.z;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s26 <= 1'b0;
		else if (en) v_s26 <= v_s25;
	end
	always_ff @(posedge clk) begin
		if (en) begin
			miss_s26 <= miss_s25;
			ip_s26   <= ip_s25;
			for (int e = 0; e < 3; e++) begin
				for (int j = 0; j < 3; j++) begin
					lp_s26[e][j] <= $signed({1'b0, xc_s25[e][j][LO-1:0]}) * ncomp[j];
					hp_s26[e][j] <= $signed(xc_s25[e][j][XW-1:LO]) * ncomp[j];
				end
			end
		end
	end

	// stage 27: partial sums
	logic v_s27, miss_s27;
	vec_t ip_s27;
	logic signed [LSW-1:0] ls_s27 [3];
	logic signed [HSW-1:0] hs_s27 [3];
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s27 <= 1'b0;
		else if (en) v_s27 <= v_s26;
	end
	always_ff @(posedge clk) begin
		if (en) begin
			miss_s27 <= miss_s26;
			ip_s27   <= ip_s26;
			for (int e = 0; e < 3; e++) begin
				ls_s27[e] <= LSW'(lp_s26[e][0]) + LSW'(lp_s26[e][1]) + LSW'(lp_s26[e][2]);
				hs_s27[e] <= HSW'(hp_s26[e][0]) + HSW'(hp_s26[e][1]) + HSW'(hp_s26[e][2]);
			end
		end
	end

	// stage 28: edge signs
	logic v_s28, miss_s28;
	vec_t ip_s28;
	logic [2:0] neg_s28, zero_s28;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s28 <= 1'b0;
		else if (en) v_s28 <= v_s27;
	end
	always_ff @(posedge clk) begin
		if (en) begin
			logic signed [PW-1:0] tot;
			miss_s28 <= miss_s27;
			ip_s28   <= ip_s27;
			for (int e = 0; e < 3; e++) begin
				tot = (PW'(hs_s27[e]) <<< LO) + PW'(ls_s27[e]);
				neg_s28[e]  <= tot[PW-1];
				zero_s28[e] <= tot == '0;
			end
		end
	end

	// stage 29: hit decision and output register
	logic hit_w;
	logic [OUT_W-1:0] hx_w, hy_w, hz_w;
	always_comb begin
		logic [2:0] pos;
		pos = ~neg_s28 & ~zero_s28;
		if (!neg_s28[0]) hit_w = !miss_s28 && pos[1] && pos[2];
		else hit_w = !miss_s28 && neg_s28[1] && neg_s28[2];
		hx_w = hit_w ? OUT_W'(ip_s28.x[OB-1:0]) : '0;
		hy_w = hit_w ? OUT_W'(ip_s28.y[OB-1:0]) : '0;
		hz_w = hit_w ? OUT_W'(ip_s28.z[OB-1:0]) : '0;
	end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) m_axis_tvalid <= 1'b0;
		else if (en) m_axis_tvalid <= v_s28;
	end
	always_ff @(posedge clk) begin
		if (en) m_axis_tdata <= M_DATA_W'({hz_w, hy_w, hx_w, hit_w});
	end
endmodule
